[sv/hsvrgb_pkg.sv]
// Shared types and constants for the HSV to RGB pixel converter.
package hsvrgb_pkg;

  localparam int SECTOR_STEPS = 43;
  localparam int OFFSET_SCALE = 6;
  localparam int FULL_LEVEL   = 255;

  localparam int MID_DEPTH  = 4;
  localparam int MID_PTR_W  = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);

  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  // Room for the queue fill plus the two words in flight in the pipeline.
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 3);

  typedef enum logic [2:0] {
    SEC_RED_TO_YELLOW,
    SEC_YELLOW_TO_GREEN,
    SEC_GREEN_TO_CYAN,
    SEC_CYAN_TO_BLUE,
    SEC_BLUE_TO_MAGENTA,
    SEC_MAGENTA_TO_RED
  } sector_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgb_t;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    logic       grey;
    sector_t    sector;
    logic [7:0] offset;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pix_class_t;

endpackage

[sv/hsvrgb_front.sv]
// Front end: accepts pixels, finds the hue sector and scaled offset, holds one word.
module hsvrgb_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  hsvrgb_pkg::hsv_t        hsv,
  output logic                    word_valid,
  input  logic                    queue_full,
  output hsvrgb_pkg::pix_class_t  word
);
  import hsvrgb_pkg::*;

  logic       valid;
  logic       valid_next;
  logic       take;
  logic       move;
  pix_class_t word_next;
  sector_t    sector;
  logic [7:0] base;
  logic [7:0] diff;

  always_comb begin
    priority if (hsv.hue >= 8'(5 * SECTOR_STEPS)) begin
      sector = SEC_MAGENTA_TO_RED;
      base   = 8'(5 * SECTOR_STEPS);
    end else if (hsv.hue >= 8'(4 * SECTOR_STEPS)) begin
      sector = SEC_BLUE_TO_MAGENTA;
      base   = 8'(4 * SECTOR_STEPS);
    end else if (hsv.hue >= 8'(3 * SECTOR_STEPS)) begin
      sector = SEC_CYAN_TO_BLUE;
      base   = 8'(3 * SECTOR_STEPS);
    end else if (hsv.hue >= 8'(2 * SECTOR_STEPS)) begin
      sector = SEC_GREEN_TO_CYAN;
      base   = 8'(2 * SECTOR_STEPS);
    end else if (hsv.hue >= 8'(SECTOR_STEPS)) begin
      sector = SEC_YELLOW_TO_GREEN;
      base   = 8'(SECTOR_STEPS);
    end else begin
      sector = SEC_RED_TO_YELLOW;
      base   = 8'd0;
    end
  end

  // The offset within a sector is at most 42, so the scaled value fits in 8 bits.
  assign diff = hsv.hue - base;

  always_comb begin
    word_next.grey       = (hsv.saturation == 8'd0);
    word_next.sector     = sector;
    word_next.offset     = 8'(diff * 8'(OFFSET_SCALE));
    word_next.saturation = hsv.saturation;
    word_next.brightness = hsv.brightness;
  end

  assign move       = valid && !queue_full;
  assign full       = valid && queue_full;
  assign take       = push && !full;
  assign valid_next = take || (valid && !move);
  assign word_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    if (take) begin
      word <= word_next;
    end
  end

endmodule

[sv/hsvrgb_queue.sv]
// Short queue of classified words between the front and back ends.
module hsvrgb_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  hsvrgb_pkg::pix_class_t  wr_word,
  output logic                    full,
  input  logic                    rd_en,
  output hsvrgb_pkg::pix_class_t  rd_word,
  output logic                    empty
);
  import hsvrgb_pkg::*;

  pix_class_t           store [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr;
  logic [MID_PTR_W-1:0] rd_ptr;
  logic [MID_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == MID_CNT_W'(MID_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      store[wr_ptr] <= wr_word;
    end
  end

endmodule

[sv/hsvrgb_back.sv]
// Back end: two-stage level pipeline, channel ordering and the result queue.
module hsvrgb_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    word_avail,
  input  hsvrgb_pkg::pix_class_t  word,
  output logic                    word_take,
  input  logic                    pop,
  output logic                    empty,
  output hsvrgb_pkg::rgb_t        rgb
);
  import hsvrgb_pkg::*;

  // Stage one: the saturation products and the p level.
  logic       v1;
  logic       grey1;
  sector_t    sector1;
  logic [7:0] val1;
  logic [7:0] dq1;
  logic [7:0] dt1;
  logic [7:0] p1;
  logic [15:0] dq_prod;
  logic [15:0] dt_prod;
  logic [15:0] p_prod;

  // Stage two: the q and t levels and the channel order.
  logic        v2;
  rgb_t        rgb2;
  rgb_t        rgb2_next;
  logic [15:0] q_prod;
  logic [15:0] t_prod;
  logic [7:0]  q;
  logic [7:0]  t;

  // Result queue.
  rgb_t                 store [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic [OUT_CNT_W-1:0] committed;
  logic                 do_rd;

  // A word is issued only when the result queue is sure to have a slot for it,
  // so the pipeline itself never has to stall.
  assign committed = count + OUT_CNT_W'(v1) + OUT_CNT_W'(v2);
  assign word_take = word_avail && (committed < OUT_CNT_W'(OUT_DEPTH));

  assign dq_prod = 16'(word.saturation) * 16'(word.offset);
  assign dt_prod = 16'(word.saturation) * 16'(8'(FULL_LEVEL) - word.offset);
  assign p_prod  = 16'(word.brightness) * 16'(8'(FULL_LEVEL) - word.saturation);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= word_take;
    end
    if (word_take) begin
      grey1   <= word.grey;
      sector1 <= word.sector;
      val1    <= word.brightness;
      dq1     <= dq_prod[15:8];
      dt1     <= dt_prod[15:8];
      p1      <= p_prod[15:8];
    end
  end

  assign q_prod = 16'(val1) * 16'(8'(FULL_LEVEL) - dq1);
  assign t_prod = 16'(val1) * 16'(8'(FULL_LEVEL) - dt1);
  assign q      = q_prod[15:8];
  assign t      = t_prod[15:8];

  always_comb begin
    if (grey1) begin
      rgb2_next = '{red_out: val1, green_out: val1, blue_out: val1};
    end else begin
      unique case (sector1)
        SEC_RED_TO_YELLOW:   rgb2_next = '{red_out: val1, green_out: t,    blue_out: p1};
        SEC_YELLOW_TO_GREEN: rgb2_next = '{red_out: q,    green_out: val1, blue_out: p1};
        SEC_GREEN_TO_CYAN:   rgb2_next = '{red_out: p1,   green_out: val1, blue_out: t};
        SEC_CYAN_TO_BLUE:    rgb2_next = '{red_out: p1,   green_out: q,    blue_out: val1};
        SEC_BLUE_TO_MAGENTA: rgb2_next = '{red_out: t,    green_out: p1,   blue_out: val1};
        default:             rgb2_next = '{red_out: val1, green_out: p1,   blue_out: q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    if (v1) begin
      rgb2 <= rgb2_next;
    end
  end

  assign empty = (count == '0);
  assign do_rd = pop && !empty;
  assign rgb   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (v2) begin
        wr_ptr <= (wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (v2 && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !v2) begin
        count <= count - 1'b1;
      end
    end
    if (v2) begin
      store[wr_ptr] <= rgb2;
    end
  end

endmodule

[sv/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB pixel converter.
//
//   channel  handshake       word   direction
//   pixel    push / full     hsv    in   (hue, saturation, brightness)
//   colour   pop  / empty    rgb    out  (red_out, green_out, blue_out)
//
// One word is accepted every clock while full is low; a result passes the front
// register, the classified-word queue, the two multiplier stages of the back end
// and the result queue before it can be popped.
// Reset (rst, synchronous) empties both queues and the pipeline; no clearing pass.
// When pop is held low the result queue fills and full rises once the middle queue
// and the front register are also occupied; either side may stall on its own.
module hsv_to_rgb_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hsvrgb_pkg::hsv_t  hsv,
  input  logic              pop,
  output logic              empty,
  output hsvrgb_pkg::rgb_t  rgb
);
  import hsvrgb_pkg::*;

  pix_class_t front_word;
  pix_class_t mid_word;
  logic       front_valid;
  logic       mid_full;
  logic       mid_empty;
  logic       mid_take;

  hsvrgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .hsv        (hsv),
    .word_valid (front_valid),
    .queue_full (mid_full),
    .word       (front_word)
  );

  hsvrgb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_word (front_word),
    .full    (mid_full),
    .rd_en   (mid_take),
    .rd_word (mid_word),
    .empty   (mid_empty)
  );

  hsvrgb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word_avail (!mid_empty),
    .word       (mid_word),
    .word_take  (mid_take),
    .pop        (pop),
    .empty      (empty),
    .rgb        (rgb)
  );

endmodule

[tb/sv/hsv_to_rgb_converter_test.sv]
// Self-checking testbench for the HSV to RGB pixel converter, with random stalls on both sides.
module hsv_to_rgb_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvrgb_pkg::*;

  localparam int PRODUCT_SHIFT = 8;
  localparam int RANDOM_PIXELS = 1150;
  localparam int SHOWN_ERRORS  = 10;
  localparam int DRAIN_CYCLES  = 12;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  hsv_t hsv   = '0;
  logic full;
  logic empty;
  rgb_t rgb;

  hsv_t pixel_queue[$];
  rgb_t rgb_awaited[$];
  int   pixels_taken  = 0;
  int   pixel_total   = 0;
  int   error_count   = 0;
  logic pixel_taken   = 1'b0;
  logic colour_taken  = 1'b0;
  logic send_calm     = 1'b0;
  logic recv_calm     = 1'b1;
  int   send_wait     = 0;
  int   recv_wait     = 0;
  int   h_list[]      = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 255};

  hsv_to_rgb_converter u_top (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .hsv   (hsv),
    .pop   (pop),
    .empty (empty),
    .rgb   (rgb)
  );

  always #6 clk = ~clk;

  function automatic rgb_t rgb_from_hsv(hsv_t px);
    int unsigned h, s, v, sec, off, p, q, t;
    sector_t     sect;
    rgb_t        c;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      c.red_out   = 8'(v);
      c.green_out = 8'(v);
      c.blue_out  = 8'(v);
      return c;
    end
    sec  = h / SECTOR_STEPS;
    off  = (h - sec * SECTOR_STEPS) * OFFSET_SCALE;
    p    = (v * (FULL_LEVEL - s)) >> PRODUCT_SHIFT;
    q    = (v * (FULL_LEVEL - ((s * off) >> PRODUCT_SHIFT))) >> PRODUCT_SHIFT;
    t    = (v * (FULL_LEVEL - ((s * (FULL_LEVEL - off)) >> PRODUCT_SHIFT))) >> PRODUCT_SHIFT;
    sect = sector_t'(3'(sec));
    case (sect)
      SEC_RED_TO_YELLOW: begin
        c = {8'(v), 8'(t), 8'(p)};
      end
      SEC_YELLOW_TO_GREEN: begin
        c = {8'(q), 8'(v), 8'(p)};
      end
      SEC_GREEN_TO_CYAN: begin
        c = {8'(p), 8'(v), 8'(t)};
      end
      SEC_CYAN_TO_BLUE: begin
        c = {8'(p), 8'(q), 8'(v)};
      end
      SEC_BLUE_TO_MAGENTA: begin
        c = {8'(t), 8'(p), 8'(v)};
      end
      default: begin
        c = {8'(v), 8'(p), 8'(q)};
      end
    endcase
    return c;
  endfunction

  // Calm stretches run without gaps; otherwise every word waits a random while.
  function automatic int draw_wait(logic calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Channel levels lean towards the ends of the range, where the arithmetic saturates.
  function automatic logic [7:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return 8'd0;
    end
    if (roll == 1) begin
      return 8'd255;
    end
    if (roll == 2) begin
      return 8'($urandom_range(1, 3));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_hue();
    int unsigned edge_sector;
    if ($urandom_range(0, 4) == 0) begin
      // Land on either side of a sector boundary.
      edge_sector = $urandom_range(1, 5);
      return 8'(edge_sector * SECTOR_STEPS - $urandom_range(0, 1));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_pixel(int h, int s, int v);
    hsv_t px;
    px.hue        = 8'(h);
    px.saturation = 8'(s);
    px.brightness = 8'(v);
    pixel_queue.push_back(px);
  endtask

  // Sender: a word stays on the port until it is taken, then the next one follows its gap.
  always @(negedge clk) begin
    if (rst) begin
      push      <= 1'b0;
      send_wait <= 0;
    end else if (!push || pixel_taken) begin
      if (pixel_taken && $urandom_range(0, 39) == 0) begin
        send_calm <= ~send_calm;
      end
      if (send_wait > 0) begin
        push      <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pixel_queue.size() > 0) begin
        hsv       <= pixel_queue.pop_front();
        push      <= 1'b1;
        send_wait <= draw_wait(send_calm);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: pop is held until a word is taken, then it may drop for a while.
  always @(negedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      recv_wait <= 0;
    end else if (!pop || colour_taken) begin
      if (colour_taken && $urandom_range(0, 39) == 0) begin
        recv_calm <= ~recv_calm;
      end
      if (recv_wait > 0) begin
        pop       <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else begin
        pop       <= 1'b1;
        recv_wait <= draw_wait(recv_calm);
      end
    end
  end

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      pixel_taken  <= 1'b0;
      colour_taken <= 1'b0;
    end else begin
      pixel_taken  <= push && !full;
      colour_taken <= pop && !empty;
      if (pop && !empty) begin
        if (rgb_awaited.size() == 0) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("%0t: unexpected word r=%0d g=%0d b=%0d", $realtime,
                     rgb.red_out, rgb.green_out, rgb.blue_out);
          end
        end else begin
          want = rgb_awaited.pop_front();
          if (rgb.red_out !== want.red_out || rgb.green_out !== want.green_out ||
              rgb.blue_out !== want.blue_out) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
              $display("%0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red_out, want.green_out, want.blue_out,
                       rgb.red_out, rgb.green_out, rgb.blue_out);
            end
          end
        end
      end
      if (push && !full) begin
        rgb_awaited.push_back(rgb_from_hsv(hsv));
        pixels_taken++;
      end
    end
  end

  initial begin
    int h;
    // Grey pixels, including black and white, and the ends of every field.
    add_pixel(0, 0, 0);
    add_pixel(255, 0, 255);
    add_pixel(100, 0, 77);
    add_pixel(0, 255, 255);
    add_pixel(255, 255, 255);
    add_pixel(255, 255, 0);
    add_pixel(128, 1, 255);
    add_pixel(200, 254, 1);
    // Both sides of each sector boundary, the last sector's short range included.
    foreach (h_list[i]) begin
      add_pixel(h_list[i], 255, 255);
    end
    add_pixel(42, 128, 200);
    add_pixel(215, 128, 200);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      h = pick_hue();
      add_pixel(h, pick_level(), pick_level());
    end
    pixel_total = pixel_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pixels_taken != pixel_total) begin
      @(posedge clk);
    end
    while (rgb_awaited.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && rgb_awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
